@@ src/sia_pkg.sv @@
// Shared types, codes and constants of the slot ID allocator.
`timescale 1ns / 1ps
`default_nettype none

package sia_pkg;

   // Default number of slots managed by the allocator.
   localparam int SLOT_COUNT_DEF = 64;

   // Occupancy bits held in one memory row, and the width of an offset inside a row.
   localparam int WORD_BITS = 16;
   localparam int OFS_W     = $clog2(WORD_BITS);

   // Operation codes.
   localparam logic [1:0] FUNC_ALLOC_NEXT  = 2'd0;
   localparam logic [1:0] FUNC_ALLOC_GIVEN = 2'd1;
   localparam logic [1:0] FUNC_FREE        = 2'd2;
   localparam logic [1:0] FUNC_QUERY       = 2'd3;

   // Status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_TAKEN = 2'd2;
   localparam logic [1:0] STATUS_EMPTY = 2'd3;

   typedef struct packed {
      logic [1:0] func;
      logic [5:0] slot_id;
      logic       parent_present;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] granted_slot;
      logic       occupied;
      logic [6:0] used_slots;
   } rsp_type;

   // Outcome of a free-slot search within one row.
   typedef struct packed {
      logic             found;
      logic [OFS_W-1:0] ofs;
   } hit_type;

endpackage

`default_nettype wire

@@ src/slot_id_allocator.sv @@
// Top level of the slot ID allocator: request sequencer, occupancy memory and counters.
`timescale 1ns / 1ps
`default_nettype none

// The allocator keeps SLOT_COUNT slots as an occupancy bitmap in a RAM of 16-bit rows, with a
// next-fit hint and a count of used slots; slot 0 is taken after reset. Each item reads one row
// and writes it back if the item changes it, so allocate-given, free and query each go through
// the row read, then the update with the result register loaded once the output is free.
// Allocate-next starts at the hint's row and, while the output is free, reads one further row
// per cycle until it finds a free slot (when all slots are used it reports full instead), and
// the extra rows that it scans number at most ceil(SLOT_COUNT/16). One item is in work at a
// time; a new item is accepted while the previous result still waits on the output, but it then
// stays in evaluation until that result leaves.
// Rows carry valid flags cleared by reset, so no clearing pass is needed.
module slot_id_allocator #(
   parameter int SLOT_COUNT = sia_pkg::SLOT_COUNT_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire sia_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      sia_pkg::rsp_type rsp_data
);

   localparam int ROWS      = (SLOT_COUNT + sia_pkg::WORD_BITS - 1) / sia_pkg::WORD_BITS;
   localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int IDX_W     = ROW_W + sia_pkg::OFS_W;
   localparam int CNT_W     = $clog2(SLOT_COUNT + 1);
   localparam int LAST_BITS = SLOT_COUNT - (ROWS - 1) * sia_pkg::WORD_BITS;
   localparam int WB        = sia_pkg::WORD_BITS;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EVAL = 1'b1;

   logic                   state_ff,   state_in;
   sia_pkg::req_type       req_ff,     req_in;
   logic                   first_ff,   first_in;
   logic [ROW_W-1:0]       cur_row_ff, cur_row_in;
   logic [IDX_W-1:0]       hint_ff,    hint_in;
   logic [CNT_W-1:0]       count_ff,   count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   sia_pkg::rsp_type       rsp_ff,     rsp_in;
   logic                   row_valid_ff [ROWS];

   logic                   req_accept;
   logic                   out_free;
   logic                   rd_en;
   logic [ROW_W-1:0]       rd_addr;
   logic                   wr_en;
   logic [WB-1:0]          rd_data;
   logic [WB-1:0]          eff_row;
   logic [WB-1:0]          new_row;
   logic [WB-1:0]          lim_mask;
   logic [sia_pkg::OFS_W-1:0] start_ofs;
   sia_pkg::hit_type       hit;

   logic [IDX_W-1:0]       sid_idx_in, sid_idx;
   logic                   sid_ok_in,  sid_ok;
   logic [ROW_W-1:0]       idle_row;
   logic [ROW_W-1:0]       next_row;
   logic [31:0]            next_row_w;
   logic                   bit_set;
   logic                   full;
   logic                   done;
   logic                   granted;
   logic [1:0]             status;
   logic [IDX_W-1:0]       slot;
   logic                   occ;
   logic [31:0]            slot_w;
   logic [31:0]            cnt_w;

   function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] idx);
      logic [31:0] nxt;
      nxt = 32'(idx) + 32'd1;
      return (nxt >= 32'(SLOT_COUNT)) ? '0 : nxt[IDX_W-1:0];
   endfunction

   sia_ram #(
      .WIDTH (WB),
      .DEPTH (ROWS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cur_row_ff),
      .wr_data (new_row),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sia_row_search u_search (
      .row_bits  (eff_row),
      .lim_mask  (lim_mask),
      .start_ofs (start_ofs),
      .hit       (hit)
   );

   assign req_stall  = reset || (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Slot addressed by an incoming item and by the item in work.
   assign sid_ok_in  = {26'd0, req_data.slot_id} < 32'(SLOT_COUNT);
   assign sid_idx_in = IDX_W'(req_data.slot_id);
   assign sid_ok     = {26'd0, req_ff.slot_id} < 32'(SLOT_COUNT);
   assign sid_idx    = IDX_W'(req_ff.slot_id);

   assign idle_row = (req_data.func == sia_pkg::FUNC_ALLOC_NEXT) ? hint_ff[IDX_W-1:sia_pkg::OFS_W]
                   : (sid_ok_in ? sid_idx_in[IDX_W-1:sia_pkg::OFS_W] : '0);

   assign next_row_w = 32'(cur_row_ff) + 32'd1;
   assign next_row   = (next_row_w >= 32'(ROWS)) ? '0 : next_row_w[ROW_W-1:0];

   // A row never written since reset reads as its reset pattern.
   assign eff_row = row_valid_ff[cur_row_ff] ? rd_data
                  : ((cur_row_ff == '0) ? WB'(1) : '0);

   always_comb begin
      for (int i = 0; i < WB; i++) begin
         lim_mask[i] = (32'(cur_row_ff) != 32'(ROWS - 1)) || (i < LAST_BITS);
      end
   end

   assign start_ofs = first_ff ? hint_ff[sia_pkg::OFS_W-1:0] : '0;
   assign bit_set   = sid_ok && eff_row[sid_idx[sia_pkg::OFS_W-1:0]];
   assign full      = 32'(count_ff) >= 32'(SLOT_COUNT);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      first_in     = first_ff;
      cur_row_in   = cur_row_ff;
      hint_in      = hint_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      rd_addr      = idle_row;
      wr_en        = 1'b0;
      new_row      = eff_row;
      status       = sia_pkg::STATUS_OK;
      slot         = sid_idx;
      occ          = bit_set;
      done         = 1'b0;
      granted      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               req_in     = req_data;
               rd_en      = 1'b1;
               cur_row_in = idle_row;
               first_in   = 1'b1;
               state_in   = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (out_free) begin
               case (req_ff.func)
                  sia_pkg::FUNC_ALLOC_NEXT: begin
                     if (full) begin
                        // Every slot is occupied, so any in-range slot reads as taken.
                        status = sia_pkg::STATUS_FULL;
                        occ    = sid_ok;
                        done   = 1'b1;
                     end else if (hit.found) begin
                        new_row  = eff_row | (WB'(1) << hit.ofs);
                        wr_en    = 1'b1;
                        slot     = {cur_row_ff, hit.ofs};
                        granted  = 1'b1;
                        occ      = 1'b1;
                        hint_in  = wrap_idx({cur_row_ff, hit.ofs});
                        count_in = count_ff + CNT_W'(1);
                        done     = 1'b1;
                     end else begin
                        rd_en      = 1'b1;
                        rd_addr    = next_row;
                        cur_row_in = next_row;
                        first_in   = 1'b0;
                     end
                  end
                  sia_pkg::FUNC_ALLOC_GIVEN: begin
                     if (!req_ff.parent_present || !sid_ok || bit_set) begin
                        status = sia_pkg::STATUS_TAKEN;
                     end else if (full) begin
                        status = sia_pkg::STATUS_FULL;
                     end else begin
                        new_row  = eff_row | (WB'(1) << sid_idx[sia_pkg::OFS_W-1:0]);
                        wr_en    = 1'b1;
                        occ      = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        if (hint_ff == sid_idx) begin
                           hint_in = wrap_idx(hint_ff);
                        end
                     end
                     done = 1'b1;
                  end
                  sia_pkg::FUNC_FREE: begin
                     if (bit_set) begin
                        new_row  = eff_row & ~(WB'(1) << sid_idx[sia_pkg::OFS_W-1:0]);
                        wr_en    = 1'b1;
                        occ      = 1'b0;
                        count_in = count_ff - CNT_W'(1);
                     end else begin
                        status = sia_pkg::STATUS_EMPTY;
                     end
                     done = 1'b1;
                  end
                  default: begin
                     status = bit_set ? sia_pkg::STATUS_OK : sia_pkg::STATUS_EMPTY;
                     done   = 1'b1;
                  end
               endcase
               if (done) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      slot_w = 32'(slot);
      cnt_w  = 32'(count_in);
      if (done) begin
         rsp_in.status       = status;
         // Without a next-fit grant the requested slot number is echoed in full.
         rsp_in.granted_slot = granted ? slot_w[5:0] : req_ff.slot_id;
         rsp_in.occupied     = occ;
         rsp_in.used_slots   = cnt_w[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         first_ff     <= 1'b0;
         hint_ff      <= IDX_W'(1);
         count_ff     <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < ROWS; r++) begin
            row_valid_ff[r] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         hint_ff      <= hint_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            row_valid_ff[cur_row_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      cur_row_ff <= cur_row_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The sequencer never reads a row in the same cycle that it writes one back.
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("row read and write-back in the same cycle");

   a_state_range: assert property (@(posedge clock) disable iff (reset)
      (32'(count_ff) <= 32'(SLOT_COUNT)) && (32'(hint_ff) < 32'(SLOT_COUNT)))
      else $error("used count or hint out of range");

   a_grant_occupied: assert property (@(posedge clock) disable iff (reset)
      (done && (status == sia_pkg::STATUS_OK) &&
       ((req_ff.func == sia_pkg::FUNC_ALLOC_NEXT) || (req_ff.func == sia_pkg::FUNC_ALLOC_GIVEN)))
      |=> (rsp_valid && rsp_data.occupied))
      else $error("granted slot not reported as occupied");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (req_stall && (state_ff == ST_EVAL)))
      else $error("accepted item did not enter evaluation");

endmodule

`default_nettype wire

@@ src/sia_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module sia_ram #(
   parameter int WIDTH = sia_pkg::WORD_BITS,
   parameter int DEPTH = sia_pkg::SLOT_COUNT_DEF / sia_pkg::WORD_BITS,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output      logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/sia_row_search.sv @@
// Finds the lowest free slot in one occupancy row at or above a start offset.
`timescale 1ns / 1ps
`default_nettype none

module sia_row_search (
   input  wire logic [sia_pkg::WORD_BITS-1:0] row_bits,
   input  wire logic [sia_pkg::WORD_BITS-1:0] lim_mask,
   input  wire logic [sia_pkg::OFS_W-1:0]     start_ofs,
   output      sia_pkg::hit_type              hit
);

   logic [sia_pkg::WORD_BITS-1:0] free_vec;

   always_comb begin
      for (int i = 0; i < sia_pkg::WORD_BITS; i++) begin
         free_vec[i] = !row_bits[i] && lim_mask[i] &&
                       (sia_pkg::OFS_W'(i) >= start_ofs);
      end
      hit.found = 1'b0;
      hit.ofs   = '0;
      // Scan downward so that the lowest free position wins.
      for (int i = sia_pkg::WORD_BITS - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            hit.found = 1'b1;
            hit.ofs   = sia_pkg::OFS_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

@@ tb/slot_id_allocator_tb.sv @@
// Self-checking testbench for the slot ID allocator: directed table, then random traffic.
`timescale 1ns / 1ps

module slot_id_allocator_tb;

   localparam int N_RANDOM    = 600;
   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic             typed;
      sia_pkg::rsp_type rs;
   } note_type;

   typedef struct packed {
      sia_pkg::req_type rq;
      note_type         nt;
   } row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid;
   logic             req_stall;
   sia_pkg::req_type req_data;
   note_type         req_note;
   logic             rsp_valid;
   logic             rsp_stall;
   sia_pkg::rsp_type rsp_data;

   // Mirror of the allocator state.
   logic [63:0] slot_map;
   logic [5:0]  scan_hint;
   logic [6:0]  used_cnt;

   sia_pkg::rsp_type expect_q[$];
   row_type          table_q[$];
   int      errors    = 0;
   int      taken_cnt = 0;
   int      cycles    = 0;
   logic    calm      = 1'b0;
   logic    sent_all  = 1'b0;

   slot_id_allocator u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one item to the mirror and returns the result the block must give.
   function automatic sia_pkg::rsp_type alloc_step(input sia_pkg::req_type rq);
      sia_pkg::rsp_type rs;
      logic [1:0] st;
      logic [5:0] slot;
      logic [5:0] h;
      st   = sia_pkg::STATUS_OK;
      slot = rq.slot_id;
      case (rq.func)
         sia_pkg::FUNC_ALLOC_NEXT: begin
            if (used_cnt < 7'd64) begin
               h = scan_hint;
               for (int n = 0; n < 64; n++) begin
                  if (slot_map[h]) h = h + 6'd1;
               end
               slot_map[h] = 1'b1;
               scan_hint   = h + 6'd1;
               used_cnt    = used_cnt + 7'd1;
               slot        = h;
            end else begin
               st = sia_pkg::STATUS_FULL;
            end
         end
         sia_pkg::FUNC_ALLOC_GIVEN: begin
            if (!rq.parent_present || slot_map[rq.slot_id]) begin
               st = sia_pkg::STATUS_TAKEN;
            end else if (used_cnt >= 7'd64) begin
               st = sia_pkg::STATUS_FULL;
            end else begin
               slot_map[rq.slot_id] = 1'b1;
               if (scan_hint == rq.slot_id) scan_hint = scan_hint + 6'd1;
               used_cnt = used_cnt + 7'd1;
            end
         end
         sia_pkg::FUNC_FREE: begin
            if (slot_map[rq.slot_id]) begin
               slot_map[rq.slot_id] = 1'b0;
               used_cnt = used_cnt - 7'd1;
            end else begin
               st = sia_pkg::STATUS_EMPTY;
            end
         end
         default: begin
            st = slot_map[rq.slot_id] ? sia_pkg::STATUS_OK : sia_pkg::STATUS_EMPTY;
         end
      endcase
      rs.status       = st;
      rs.granted_slot = slot;
      rs.occupied     = slot_map[slot];
      rs.used_slots   = used_cnt;
      return rs;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   task automatic add_row(input logic [1:0] fn, input logic [5:0] sid, input logic par,
                          input logic typed, input sia_pkg::rsp_type rs);
      row_type r;
      r.rq.func           = fn;
      r.rq.slot_id        = sid;
      r.rq.parent_present = par;
      r.nt.typed          = typed;
      r.nt.rs             = rs;
      table_q.push_back(r);
   endtask

   initial begin
      slot_map  = 64'd1;
      scan_hint = 6'd1;
      used_cnt  = 7'd1;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("[slot_id_allocator] ERROR");
         $finish;
      end
   end

   // Results are checked before the item accepted at the same edge is predicted;
   // a result can never belong to an item accepted at that edge.
   always @(posedge clock) begin : monitor
      sia_pkg::rsp_type want;
      sia_pkg::rsp_type pred;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expect_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
               errors++;
            end else begin
               want = expect_q.pop_front();
               check_field("status", want.status, rsp_data.status);
               check_field("granted_slot", want.granted_slot, rsp_data.granted_slot);
               check_field("occupied", want.occupied, rsp_data.occupied);
               check_field("used_slots", want.used_slots, rsp_data.used_slots);
            end
         end
         if (req_valid && !req_stall) begin
            pred = alloc_step(req_data);
            expect_q.push_back(req_note.typed ? req_note.rs : pred);
            taken_cnt <= taken_cnt + 1;
         end
      end
   end

   initial begin : sender
      sia_pkg::req_type it;
      note_type nt;
      row_type  r;
      int       total;
      int       phase_left;
      int       pick;
      logic     filling;
      logic     quiet;
      req_valid = 1'b0;
      req_data  = '0;
      req_note  = '0;
      // Typed rows can be read straight off the state after reset.
      add_row(sia_pkg::FUNC_QUERY, 6'd0, 1'b0, 1'b1,
              '{sia_pkg::STATUS_OK, 6'd0, 1'b1, 7'd1});
      add_row(sia_pkg::FUNC_QUERY, 6'd63, 1'b1, 1'b1,
              '{sia_pkg::STATUS_EMPTY, 6'd63, 1'b0, 7'd1});
      add_row(sia_pkg::FUNC_ALLOC_NEXT, 6'd63, 1'b0, 1'b1,
              '{sia_pkg::STATUS_OK, 6'd1, 1'b1, 7'd2});
      add_row(sia_pkg::FUNC_ALLOC_GIVEN, 6'd63, 1'b1, 1'b1,
              '{sia_pkg::STATUS_OK, 6'd63, 1'b1, 7'd3});
      add_row(sia_pkg::FUNC_ALLOC_GIVEN, 6'd63, 1'b1, 1'b1,
              '{sia_pkg::STATUS_TAKEN, 6'd63, 1'b1, 7'd3});
      add_row(sia_pkg::FUNC_ALLOC_GIVEN, 6'd5, 1'b0, 1'b1,
              '{sia_pkg::STATUS_TAKEN, 6'd5, 1'b0, 7'd3});
      add_row(sia_pkg::FUNC_FREE, 6'd10, 1'b1, 1'b1,
              '{sia_pkg::STATUS_EMPTY, 6'd10, 1'b0, 7'd3});
      add_row(sia_pkg::FUNC_FREE, 6'd0, 1'b0, 1'b1,
              '{sia_pkg::STATUS_OK, 6'd0, 1'b0, 7'd2});
      add_row(sia_pkg::FUNC_QUERY, 6'd0, 1'b1, 1'b1,
              '{sia_pkg::STATUS_EMPTY, 6'd0, 1'b0, 7'd2});
      // Allocating the slot under the hint pushes the hint past it.
      add_row(sia_pkg::FUNC_ALLOC_GIVEN, 6'd2, 1'b1, 1'b1,
              '{sia_pkg::STATUS_OK, 6'd2, 1'b1, 7'd3});
      add_row(sia_pkg::FUNC_ALLOC_NEXT, 6'd0, 1'b1, 1'b1,
              '{sia_pkg::STATUS_OK, 6'd3, 1'b1, 7'd4});
      add_row(sia_pkg::FUNC_FREE, 6'd63, 1'b0, 1'b1,
              '{sia_pkg::STATUS_OK, 6'd63, 1'b0, 7'd3});
      add_row(sia_pkg::FUNC_ALLOC_GIVEN, 6'd4, 1'b1, 1'b0, '0);
      add_row(sia_pkg::FUNC_ALLOC_GIVEN, 6'd0, 1'b1, 1'b0, '0);
      add_row(sia_pkg::FUNC_ALLOC_NEXT, 6'd42, 1'b1, 1'b0, '0);
      add_row(sia_pkg::FUNC_ALLOC_GIVEN, 6'd62, 1'b1, 1'b0, '0);
      add_row(sia_pkg::FUNC_ALLOC_GIVEN, 6'd63, 1'b1, 1'b0, '0);
      add_row(sia_pkg::FUNC_ALLOC_NEXT, 6'd21, 1'b0, 1'b0, '0);
      add_row(sia_pkg::FUNC_FREE, 6'd62, 1'b1, 1'b0, '0);
      add_row(sia_pkg::FUNC_QUERY, 6'd62, 1'b0, 1'b0, '0);
      add_row(sia_pkg::FUNC_QUERY, 6'd63, 1'b1, 1'b0, '0);
      add_row(sia_pkg::FUNC_FREE, 6'd63, 1'b0, 1'b0, '0);
      add_row(sia_pkg::FUNC_FREE, 6'd63, 1'b1, 1'b0, '0);
      total      = table_q.size() + N_RANDOM;
      phase_left = 0;
      filling    = 1'b1;
      wait (!reset);
      @(negedge clock);
      for (int i = 0; i < total; i++) begin
         if (i < table_q.size()) begin
            r  = table_q[i];
            it = r.rq;
            nt = r.nt;
         end else begin
            // Alternate fill and drain phases so the set runs full and back down.
            if (phase_left == 0) begin
               filling    = !filling;
               phase_left = $urandom_range(120, 60);
            end
            phase_left--;
            pick               = $urandom_range(99);
            it.slot_id         = 6'($urandom_range(63));
            it.parent_present  = ($urandom_range(99) < 85);
            if (filling) begin
               it.func = (pick < 60) ? sia_pkg::FUNC_ALLOC_NEXT :
                         (pick < 80) ? sia_pkg::FUNC_ALLOC_GIVEN :
                         (pick < 90) ? sia_pkg::FUNC_FREE : sia_pkg::FUNC_QUERY;
            end else begin
               it.func = (pick < 65) ? sia_pkg::FUNC_FREE :
                         (pick < 75) ? sia_pkg::FUNC_ALLOC_NEXT :
                         (pick < 85) ? sia_pkg::FUNC_ALLOC_GIVEN : sia_pkg::FUNC_QUERY;
            end
            nt = '0;
         end
         quiet = (i >= 400 && i < 520);
         calm <= quiet;
         while (!quiet && $urandom_range(99) < 37) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
         req_valid <= 1'b1;
         req_data  <= it;
         req_note  <= nt;
         do @(posedge clock); while (req_stall);
         @(negedge clock);
      end
      req_valid <= 1'b0;
      sent_all  <= 1'b1;
   end

   initial begin : receiver
      logic held;
      held      = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && taken_cnt >= 150) begin
            // Long hold-off: the sender keeps offering until the block backs up.
            held = 1'b1;
            rsp_stall <= 1'b1;
            for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clock);
         end
         rsp_stall <= !calm && ($urandom_range(99) < 37);
      end
   end

   initial begin : finisher
      wait (sent_all);
      while (expect_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("[slot_id_allocator] OK");
      end else begin
         $display("[slot_id_allocator] ERROR");
      end
      $finish;
   end

endmodule
